// ===== rtl/core/rcbhd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcbhd_pkg: shared definitions for the RC receiver bind and hop decoder
// Register indexes, payload layout, hop frequency table and packet constants.
// ----------------------------------------------------------------------------
package rcbhd_pkg;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_FAILSAFE_LIMIT = 1'b0,
      CSR_BIND_CHANNEL   = 1'b1
   } csr_index_type;

   // Item kinds carried on req_tuser
   localparam logic REQ_PACKET = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // Register reset values and widths
   localparam int          LIMIT_W              = 24;
   localparam int          CHAN_W               = 7;
   localparam logic [23:0] FAILSAFE_LIMIT_RESET = 24'd1000000;
   localparam logic [6:0]  BIND_CHANNEL_RESET   = 7'd22;
   localparam logic [15:0] ADDR_RESET           = 16'hCCCC;

   // Hop timing
   localparam int HOP_PERIOD_DEFAULT = 2625;
   localparam int HOP_SLOTS          = 16;
   localparam int SLOT_W             = $clog2(HOP_SLOTS);

   // Packet constants
   localparam logic [7:0] BIND_MARKER  = 8'h20;
   localparam logic [8:0] THROTTLE_REF = 9'd225;
   localparam logic [8:0] STICK_MID    = 9'd112;
   localparam int         FLIP_BIT     = 7;
   localparam int         VIDEO_BIT    = 4;
   localparam int         FS_SW_BIT    = 0;

   // Channel widths
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 72;

   // Result layout, lowest bit up
   localparam int RSP_BOUND_BIT  = 7;
   localparam int RSP_ACCEPT_BIT = 8;
   localparam int RSP_FS_BIT     = 9;
   localparam int RSP_STICK_LO   = 10;
   localparam int RSP_STICK_HI   = 45;
   localparam int RSP_PAD_LO     = 65;

   // Result fields above rf_channel; last member sits in the lowest bits
   typedef struct packed {
      logic [15:0] link_address;
      logic        fs_switch_flag;
      logic        video_flag;
      logic        flip_flag;
      logic [8:0]  yaw_value;
      logic [8:0]  pitch_value;
      logic [8:0]  roll_value;
      logic [8:0]  throttle_value;
      logic        failsafe_active;
      logic        packet_accepted;
      logic        bound;
   } rsp_info_type;

   // Hop frequency table
   function automatic logic [6:0] hop_channel(input logic [SLOT_W-1:0] slot);
      logic [6:0] chan;
      unique case (slot)
         4'd0:    chan = 7'h02;
         4'd1:    chan = 7'h48;
         4'd2:    chan = 7'h0C;
         4'd3:    chan = 7'h3E;
         4'd4:    chan = 7'h16;
         4'd5:    chan = 7'h34;
         4'd6:    chan = 7'h20;
         4'd7:    chan = 7'h2A;
         4'd8:    chan = 7'h2A;
         4'd9:    chan = 7'h20;
         4'd10:   chan = 7'h34;
         4'd11:   chan = 7'h16;
         4'd12:   chan = 7'h3E;
         4'd13:   chan = 7'h0C;
         4'd14:   chan = 7'h48;
         default: chan = 7'h02;
      endcase
      return chan;
   endfunction

endpackage

// ===== rtl/core/rc_receiver_bind_hop_decode_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_receiver_bind_hop_decode_top: RC link receiver bind, hop and failsafe
// Decodes bind and control packets, checks the checksum, picks the next hop
// channel from packet and tick timing and raises failsafe on link loss.
// ----------------------------------------------------------------------------
// An accepted item passes stages 1 to 5 and the output register before rsp_tvalid rises.
// Throughput: one item per cycle unless output back-pressure fills the pipeline; five
// stages and an output register, each stage holding or passing its item on its own
// ready, so req_tready stays high while a result waits unless all stages are full.
// The hop slot divide by HOP_PERIOD is a reciprocal multiply spread over stages 2 to 5.
// Reset (synchronous): pipeline empty, registers and link state at reset values.
module rc_receiver_bind_hop_decode_top
   import rcbhd_pkg::*;
#(
   parameter int HOP_PERIOD = HOP_PERIOD_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // event_time[31:0], pay_byte0 .. pay_byte8 in 8-bit steps up to [103:96]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic                  req_tuser,
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rf_channel[6:0], bound, packet_accepted, failsafe_active, throttle_value,
   // roll_value, pitch_value, yaw_value (9 each), flip_flag, video_flag,
   // fs_switch_flag, link_address[64:49], zero fill [71:65]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Reciprocal for the exact quotient of a 32-bit value by HOP_PERIOD
   localparam int          RECIP_K    = $clog2(HOP_PERIOD);
   localparam int          QSHIFT     = 32 + RECIP_K;
   localparam logic [48:0] RECIP_WIDE = (49'd1 << QSHIFT) / 49'(HOP_PERIOD);
   localparam logic [32:0] RECIP      = RECIP_WIDE[32:0];
   localparam logic [31:0] PERIOD     = 32'(HOP_PERIOD);

   typedef struct packed {
      logic         hop;
      logic [2:0]   chan_off;
      logic [31:0]  elapsed;
      rsp_info_type info;
   } stage_type;

   // Configuration registers; the bind channel value matters only at the
   // moment it is written, when it retunes the radio before bind
   logic [LIMIT_W-1:0] limit_ff;

   // Link state updated at stage 1
   logic               bound_ff, bound_in;
   logic [31:0]        last_time_ff, last_time_in;
   logic [2:0]         chan_off_ff, chan_off_in;
   logic [7:0]         sum_off_ff, sum_off_in;
   logic [15:0]        addr_ff, addr_in;
   logic [8:0]         throttle_ff, throttle_in;
   logic [8:0]         roll_ff, roll_in;
   logic [8:0]         pitch_ff, pitch_in;
   logic [8:0]         yaw_ff, yaw_in;
   logic               flip_ff, flip_in;
   logic               video_ff, video_in;
   logic               fs_sw_ff, fs_sw_in;

   // Hop state updated at the last stage
   logic [SLOT_W-1:0]  hop_slot_ff, hop_slot_in;
   logic [SLOT_W-1:0]  last_slot_ff, last_slot_in;
   logic [CHAN_W-1:0]  tuned_ff, tuned_in;

   // Pipeline valid bits and ready chain
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, out_v_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, out_rdy;

   // Stage payloads
   logic                  s1_kind_ff;
   logic [REQ_DATA_W-1:0] s1_data_ff;
   stage_type             s2_ff, s3_ff, s4_ff, s5_ff;
   stage_type             s2_in;
   logic [48:0]           s3_pp_lo_ff, s3_pp_lo_in;
   logic [47:0]           s3_pp_hi_ff, s3_pp_hi_in;
   logic [31:0]           s4_q0_ff, s4_q0_in;
   logic [31:0]           s5_q0_ff;
   logic [31:0]           s5_qp_ff, s5_qp_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   // Stage 1 decode signals
   logic [7:0]  pb [9];
   logic [31:0] now;
   logic [31:0] elapsed_raw;
   logic [31:0] elapsed_eff;
   logic [7:0]  sum8;
   logic        is_tick, bind_pkt, good_pkt, acc, fs;

   // Stage 2 and stage 3 arithmetic
   logic [64:0] prod;

   // Last stage hop signals
   logic [31:0]       rem;
   logic [31:0]       quot;
   logic [SLOT_W-1:0] step;
   logic [SLOT_W-1:0] base_slot;
   logic [SLOT_W-1:0] new_slot;
   logic [CHAN_W-1:0] new_chan;

   // Ready chain: a stage takes an item when empty or when it passes its own
   assign out_rdy    = !out_v_ff || rsp_tready;
   assign s5_rdy     = !s5_v_ff || out_rdy;
   assign s4_rdy     = !s4_v_ff || s5_rdy;
   assign s3_rdy     = !s3_v_ff || s4_rdy;
   assign s2_rdy     = !s2_v_ff || s3_rdy;
   assign s1_rdy     = !s1_v_ff || s2_rdy;
   assign req_tready = s1_rdy;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_rdy)  s1_v_ff  <= req_tvalid;
         if (s2_rdy)  s2_v_ff  <= s1_v_ff;
         if (s3_rdy)  s3_v_ff  <= s2_v_ff;
         if (s4_rdy)  s4_v_ff  <= s3_v_ff;
         if (s5_rdy)  s5_v_ff  <= s4_v_ff;
         if (out_rdy) out_v_ff <= s5_v_ff;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_kind_ff <= req_tuser;
         s1_data_ff <= req_tdata;
      end
   end

   // Stage 1: decode packet, check sum, update link state, measure elapsed
   always_comb begin
      now = s1_data_ff[31:0];
      for (int i = 0; i < 9; i++) begin
         pb[i] = s1_data_ff[32 + 8*i +: 8];
      end
      is_tick     = (s1_kind_ff == REQ_TICK);
      elapsed_raw = now - last_time_ff;
      sum8 = sum_off_ff + pb[0] + pb[1] + pb[2] + pb[3]
           + pb[4] + pb[5] + pb[6] + pb[7];
      bind_pkt    = !is_tick && !bound_ff && (pb[0] == BIND_MARKER);
      good_pkt    = !is_tick && bound_ff && (sum8 == pb[8]);
      acc         = bind_pkt || good_pkt;
      elapsed_eff = acc ? 32'd0 : elapsed_raw;
      fs          = (elapsed_eff > {8'd0, limit_ff});

      // bind fields
      bound_in     = bound_ff || bind_pkt;
      last_time_in = acc ? now : last_time_ff;
      chan_off_in  = chan_off_ff;
      sum_off_in   = sum_off_ff;
      addr_in      = addr_ff;
      if (bind_pkt) begin
         chan_off_in = 3'({1'b0, pb[7][7:4]} + {1'b0, pb[7][3:0]});
         sum_off_in  = pb[7];
         addr_in     = {pb[5], pb[4]};
      end

      // sticks and switches from a good packet, sticks dropped in failsafe
      throttle_in = throttle_ff;
      roll_in     = roll_ff;
      pitch_in    = pitch_ff;
      yaw_in      = yaw_ff;
      flip_in     = flip_ff;
      video_in    = video_ff;
      fs_sw_in    = fs_sw_ff;
      if (good_pkt) begin
         throttle_in = THROTTLE_REF - {1'b0, pb[0]};
         roll_in     = {1'b0, pb[2]} - STICK_MID;
         pitch_in    = {1'b0, pb[3]} - STICK_MID;
         yaw_in      = STICK_MID - {1'b0, pb[1]};
         flip_in     = pb[6][FLIP_BIT];
         video_in    = pb[6][VIDEO_BIT];
         fs_sw_in    = pb[6][FS_SW_BIT];
      end
      if (fs) begin
         throttle_in = 9'd0;
         roll_in     = 9'd0;
         pitch_in    = 9'd0;
         yaw_in      = 9'd0;
      end

      s2_in.hop                  = is_tick || acc;
      s2_in.chan_off             = chan_off_in;
      s2_in.elapsed              = elapsed_eff;
      s2_in.info.link_address    = addr_in;
      s2_in.info.fs_switch_flag  = fs_sw_in;
      s2_in.info.video_flag      = video_in;
      s2_in.info.flip_flag       = flip_in;
      s2_in.info.yaw_value       = yaw_in;
      s2_in.info.pitch_value     = pitch_in;
      s2_in.info.roll_value      = roll_in;
      s2_in.info.throttle_value  = throttle_in;
      s2_in.info.failsafe_active = fs;
      s2_in.info.packet_accepted = acc;
      s2_in.info.bound           = bound_in;
   end

   // Commit link state as the item leaves stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff     <= 1'b0;
         last_time_ff <= 32'd0;
         chan_off_ff  <= 3'd0;
         sum_off_ff   <= 8'd0;
         addr_ff      <= ADDR_RESET;
         throttle_ff  <= 9'd0;
         roll_ff      <= 9'd0;
         pitch_ff     <= 9'd0;
         yaw_ff       <= 9'd0;
         flip_ff      <= 1'b0;
         video_ff     <= 1'b0;
         fs_sw_ff     <= 1'b0;
      end else if (s1_v_ff && s2_rdy) begin
         bound_ff     <= bound_in;
         last_time_ff <= last_time_in;
         chan_off_ff  <= chan_off_in;
         sum_off_ff   <= sum_off_in;
         addr_ff      <= addr_in;
         throttle_ff  <= throttle_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
         flip_ff      <= flip_in;
         video_ff     <= video_in;
         fs_sw_ff     <= fs_sw_in;
      end
   end

   // Stage 2: partial products of elapsed times the reciprocal
   assign s3_pp_lo_in = 49'(s2_ff.elapsed) * 49'(RECIP[16:0]);
   assign s3_pp_hi_in = 48'(s2_ff.elapsed) * 48'(RECIP[32:17]);

   // Stage 3: sum partial products, take the estimated quotient
   assign prod     = 65'(s3_pp_lo_ff) + (65'(s3_pp_hi_ff) << 17);
   assign s4_q0_in = 32'(prod >> QSHIFT);

   // Stage 4: multiply the estimate back by the period
   assign s5_qp_in = 32'(48'(s4_q0_ff) * 48'(PERIOD[15:0]));

   // Stage payload registers
   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_ff <= s2_in;
      end
      if (s3_rdy) begin
         s3_ff       <= s2_ff;
         s3_pp_lo_ff <= s3_pp_lo_in;
         s3_pp_hi_ff <= s3_pp_hi_in;
      end
      if (s4_rdy) begin
         s4_ff    <= s3_ff;
         s4_q0_ff <= s4_q0_in;
      end
      if (s5_rdy) begin
         s5_ff    <= s4_ff;
         s5_q0_ff <= s4_q0_ff;
         s5_qp_ff <= s5_qp_in;
      end
   end

   // Stage 5: correct the quotient, pick the hop slot and channel
   always_comb begin
      rem  = s5_ff.elapsed - s5_qp_ff;
      quot = s5_q0_ff + ((rem >= PERIOD) ? 32'd1 : 32'd0);
      step = (quot > 32'(HOP_SLOTS)) ? quot[2*SLOT_W-1:SLOT_W] : quot[SLOT_W-1:0];
      // an accepted packet hops from the slot it arrived on
      base_slot = s5_ff.info.packet_accepted ? hop_slot_ff : last_slot_ff;
      new_slot  = base_slot + step + SLOT_W'(1);
      new_chan  = hop_channel(new_slot) + CHAN_W'(s5_ff.chan_off);

      hop_slot_in  = hop_slot_ff;
      last_slot_in = last_slot_ff;
      tuned_in     = tuned_ff;
      if (s5_ff.info.packet_accepted) begin
         last_slot_in = hop_slot_ff;
      end
      if (s5_ff.hop) begin
         hop_slot_in = new_slot;
         tuned_in    = new_chan;
      end
      out_data_in = {(RSP_DATA_W - RSP_PAD_LO)'(0), s5_ff.info, tuned_in};
   end

   // Commit hop state as the item enters the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         hop_slot_ff  <= '0;
         last_slot_ff <= '0;
         tuned_ff     <= BIND_CHANNEL_RESET;
      end else if (s5_v_ff && out_rdy) begin
         hop_slot_ff  <= hop_slot_in;
         last_slot_ff <= last_slot_in;
         tuned_ff     <= tuned_in;
      end else if (csr_valid && (csr_index_type'(csr_index) == CSR_BIND_CHANNEL)
                   && !bound_ff) begin
         // before bind the radio follows the bind channel register
         tuned_ff <= csr_data[CHAN_W-1:0];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (out_rdy) begin
         out_data_ff <= out_data_in;
      end
   end

   // Failsafe limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= FAILSAFE_LIMIT_RESET;
      end else if (csr_valid && (csr_index_type'(csr_index) == CSR_FAILSAFE_LIMIT)) begin
         limit_ff <= csr_data[LIMIT_W-1:0];
      end
   end

endmodule

// ===== rtl/core/rcbhd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcbhd_checker: port checks for the RC receiver bind and hop decoder
// Watches the result stream and ties its flags together over time.
// ----------------------------------------------------------------------------
module rcbhd_checker
   import rcbhd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [0:0]            csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // Drop sticks whenever failsafe is shown
   a_fs_sticks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_FS_BIT] |-> rsp_tdata[RSP_STICK_HI:RSP_STICK_LO] == '0)
      else $error("sticks not cleared in failsafe");

   // An accepted packet restarts the failsafe timer and leaves the link bound
   a_acc_no_fs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_ACCEPT_BIT]
      |-> !rsp_tdata[RSP_FS_BIT] && rsp_tdata[RSP_BOUND_BIT])
      else $error("accepted packet shows failsafe or unbound link");

   // Keep the link bound once a result has shown it bound
   a_bound_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tdata[RSP_BOUND_BIT] ##1 rsp_tvalid
      |-> rsp_tdata[RSP_BOUND_BIT])
      else $error("bound flag fell without reset");

endmodule

bind rc_receiver_bind_hop_decode_top rcbhd_checker u_rcbhd_checker (.*);

// ===== test/tb_rc_receiver_bind_hop_decode_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc_receiver_bind_hop_decode_top: regression for the RC bind and hop decoder
// Drives bind, control and tick items with random handshake gaps and checks
// every result against a cycle-free predictor of link state, hop slot
// selection and failsafe. Covers bind mode, stick extremes, hop timing edges,
// failsafe limits, output back-pressure and long random traffic runs.
// ----------------------------------------------------------------------------
module tb_rc_receiver_bind_hop_decode_top;
   import rcbhd_pkg::*;

   localparam int          HOP_PERIOD   = HOP_PERIOD_DEFAULT;
   localparam logic [31:0] HOP_PERIOD_U = 32'(HOP_PERIOD);

   // Result word as it leaves the block, lowest field last
   typedef struct packed {
      logic [6:0]   pad;
      rsp_info_type info;
      logic [6:0]   rf_channel;
   } rsp_word_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [0:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Handshake shaping
   int req_gap_max;
   int rsp_gap_max;
   int rsp_hold_cycles;

   // Run statistics
   int num_errors;
   int num_checked;
   int num_items;
   int num_ticks;
   int num_good;
   int num_fs;
   int num_csr_writes;

   // Running event time and the results still in flight
   logic [31:0]  evt_time;
   rsp_word_type link_result_q[$];

   // Receiver link state as predicted
   logic [23:0] rx_limit;
   logic [6:0]  rx_bind_chan;
   logic        rx_bound;
   logic [3:0]  rx_slot;
   logic [3:0]  rx_good_slot;
   logic [31:0] rx_good_time;
   logic [6:0]  rx_chan;
   logic [2:0]  rx_chan_ofs;
   logic [7:0]  rx_sum_ofs;
   logic [15:0] rx_addr;
   logic [8:0]  rx_throttle;
   logic [8:0]  rx_roll;
   logic [8:0]  rx_pitch;
   logic [8:0]  rx_yaw;
   logic        rx_flip;
   logic        rx_video;
   logic        rx_fs_sw;

   rc_receiver_bind_hop_decode_top #(
      .HOP_PERIOD (HOP_PERIOD)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Frequency table of the hop sequence
   function automatic logic [6:0] hop_freq(input logic [3:0] slot);
      case (slot)
         4'd0:    return 7'h02;
         4'd1:    return 7'h48;
         4'd2:    return 7'h0C;
         4'd3:    return 7'h3E;
         4'd4:    return 7'h16;
         4'd5:    return 7'h34;
         4'd6:    return 7'h20;
         4'd7:    return 7'h2A;
         4'd8:    return 7'h2A;
         4'd9:    return 7'h20;
         4'd10:   return 7'h34;
         4'd11:   return 7'h16;
         4'd12:   return 7'h3E;
         4'd13:   return 7'h0C;
         4'd14:   return 7'h48;
         default: return 7'h02;
      endcase
   endfunction

   function automatic void reset_link_state();
      rx_limit     = FAILSAFE_LIMIT_RESET;
      rx_bind_chan = BIND_CHANNEL_RESET;
      rx_bound     = 1'b0;
      rx_slot      = '0;
      rx_good_slot = '0;
      rx_good_time = '0;
      rx_chan      = BIND_CHANNEL_RESET;
      rx_chan_ofs  = '0;
      rx_sum_ofs   = '0;
      rx_addr      = ADDR_RESET;
      rx_throttle  = '0;
      rx_roll      = '0;
      rx_pitch     = '0;
      rx_yaw       = '0;
      rx_flip      = 1'b0;
      rx_video     = 1'b0;
      rx_fs_sw     = 1'b0;
   endfunction

   // Pick the next slot from the time since the last good packet
   function automatic void advance_hop(input logic [31:0] now);
      logic [31:0] elapsed;
      logic [31:0] hops;
      elapsed = now - rx_good_time;
      hops    = elapsed / HOP_PERIOD_U;
      if (hops > HOP_SLOTS)
         hops = hops / HOP_SLOTS;
      hops    = hops + 1;
      rx_slot = rx_good_slot + hops[3:0];
      rx_chan = hop_freq(rx_slot) + {4'd0, rx_chan_ofs};
   endfunction

   function automatic logic [7:0] pay_checksum(input logic [8:0][7:0] pay);
      logic [7:0] sum;
      sum = rx_sum_ofs;
      for (int i = 0; i < 8; i++)
         sum = sum + pay[i];
      return sum;
   endfunction

   // Update the link state for one item and build its result
   function automatic rsp_word_type predict_link_result(input logic kind,
                                                        input logic [31:0] now,
                                                        input logic [8:0][7:0] pay);
      rsp_word_type res;
      logic         accepted;
      logic         fs;
      logic [4:0]   nib_sum;
      res      = '0;
      accepted = 1'b0;
      if (kind == REQ_TICK) begin
         advance_hop(now);
      end else if (!rx_bound) begin
         // bind mode: only the bind marker is taken
         if (pay[0] == BIND_MARKER) begin
            rx_addr     = {pay[5], pay[4]};
            nib_sum     = pay[7][7:4] + pay[7][3:0];
            rx_chan_ofs = nib_sum[2:0];
            rx_sum_ofs  = pay[7];
            rx_bound    = 1'b1;
            accepted    = 1'b1;
         end
      end else if (pay_checksum(pay) == pay[8]) begin
         rx_throttle = THROTTLE_REF - {1'b0, pay[0]};
         rx_roll     = {1'b0, pay[2]} - STICK_MID;
         rx_pitch    = {1'b0, pay[3]} - STICK_MID;
         rx_yaw      = STICK_MID - {1'b0, pay[1]};
         rx_flip     = pay[6][FLIP_BIT];
         rx_video    = pay[6][VIDEO_BIT];
         rx_fs_sw    = pay[6][FS_SW_BIT];
         accepted    = 1'b1;
      end
      if (accepted) begin
         rx_good_slot = rx_slot;
         rx_good_time = now;
         advance_hop(now);
      end
      // failsafe drops the sticks but keeps the switches
      fs = (now - rx_good_time) > {8'd0, rx_limit};
      if (fs) begin
         rx_throttle = '0;
         rx_roll     = '0;
         rx_pitch    = '0;
         rx_yaw      = '0;
      end
      res.rf_channel               = rx_chan;
      res.info.bound               = rx_bound;
      res.info.packet_accepted     = accepted;
      res.info.failsafe_active     = fs;
      res.info.throttle_value      = rx_throttle;
      res.info.roll_value          = rx_roll;
      res.info.pitch_value         = rx_pitch;
      res.info.yaw_value           = rx_yaw;
      res.info.flip_flag           = rx_flip;
      res.info.video_flag          = rx_video;
      res.info.fs_switch_flag      = rx_fs_sw;
      res.info.link_address        = rx_addr;
      return res;
   endfunction

   function automatic logic [8:0][7:0] rand_pay();
      logic [8:0][7:0] p;
      for (int i = 0; i < 9; i++)
         p[i] = 8'($urandom);
      return p;
   endfunction

   // Mostly short steps, some hop-scale gaps, a few link losses and wraps
   function automatic logic [31:0] next_time_step();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return $urandom_range(0, 3000);
      else if (pick < 90)
         return $urandom_range(0, 60000);
      else if (pick < 98)
         return $urandom_range(0, 2000000);
      return $urandom;
   endfunction

   task automatic check_field(input string fname, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, fname, exp_v, act_v);
         num_errors++;
      end
   endtask

   // Offer one item after a random gap and record its expected result
   task automatic send_item(input logic kind, input logic [31:0] now,
                            input logic [8:0][7:0] pay);
      int           gap;
      rsp_word_type res;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {pay, now};
      do @(posedge clock); while (req_tready !== 1'b1);
      res = predict_link_result(kind, now, pay);
      link_result_q.push_back(res);
      num_items++;
      if (kind == REQ_TICK)
         num_ticks++;
      if (res.info.packet_accepted)
         num_good++;
      if (res.info.failsafe_active)
         num_fs++;
   endtask

   task automatic send_after(input logic kind, input logic [31:0] dt,
                             input logic [8:0][7:0] pay);
      evt_time = evt_time + dt;
      send_item(kind, evt_time, pay);
   endtask

   task automatic send_good_packet(input logic [31:0] dt, input logic [8:0][7:0] pay);
      pay[8] = pay_checksum(pay);
      send_after(REQ_PACKET, dt, pay);
   endtask

   task automatic send_random_item();
      logic [8:0][7:0] pay;
      logic            kind;
      int              pick;
      pick     = $urandom_range(0, 99);
      pay      = rand_pay();
      kind     = (pick < 35) ? REQ_TICK : REQ_PACKET;
      // most packets carry a good checksum, the rest are noise
      if (kind == REQ_PACKET && pick < 85)
         pay[8] = pay_checksum(pay);
      send_after(kind, next_time_step(), pay);
   endtask

   // Stop offering and wait until every result is back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (link_result_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [23:0] value);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_FAILSAFE_LIMIT) begin
         rx_limit = value;
      end else begin
         rx_bind_chan = value[6:0];
         if (!rx_bound)
            rx_chan = rx_bind_chan;
      end
      num_csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Bind mode: rejects, channel writes, ticks, then the bind itself
   task automatic test_bind_mode();
      logic [8:0][7:0] pay;
      pay = '0;
      send_item(REQ_PACKET, 32'd100, pay);
      write_csr(CSR_BIND_CHANNEL, 24'd127);
      pay = {9{8'hFF}};
      send_item(REQ_PACKET, 32'd105, pay);
      write_csr(CSR_BIND_CHANNEL, 24'd0);
      pay    = '0;
      pay[0] = BIND_MARKER + 8'd1;
      send_item(REQ_PACKET, 32'd110, pay);
      // hop boundaries with no offset yet, then a wrapped gap
      send_item(REQ_TICK, HOP_PERIOD_U - 1, rand_pay());
      send_item(REQ_TICK, HOP_PERIOD_U, rand_pay());
      send_item(REQ_TICK, 16 * HOP_PERIOD_U, rand_pay());
      send_item(REQ_TICK, 17 * HOP_PERIOD_U, rand_pay());
      send_item(REQ_TICK, 32'hFFFF_FFFF, rand_pay());
      write_csr(CSR_BIND_CHANNEL, 24'(BIND_CHANNEL_RESET));
      pay    = rand_pay();
      pay[0] = BIND_MARKER - 8'd1;
      send_item(REQ_PACKET, 32'd1000, pay);
      pay    = rand_pay();
      pay[0] = BIND_MARKER;
      evt_time = 32'd2000;
      send_item(REQ_PACKET, evt_time, pay);
   endtask

   // Stick and switch extremes, a bad checksum and a marker in normal mode
   task automatic test_stick_extremes();
      logic [8:0][7:0] pay;
      write_csr(CSR_FAILSAFE_LIMIT, 24'hFF_FFFF);
      pay = '0;
      send_good_packet(100, pay);
      pay = {9{8'hFF}};
      send_good_packet(100, pay);
      pay    = {9{8'h70}};
      pay[6] = 8'h80;
      send_good_packet(100, pay);
      pay[6] = 8'h11;
      send_good_packet(100, pay);
      pay    = rand_pay();
      pay[8] = pay_checksum(pay) + 8'd1;
      send_after(REQ_PACKET, 100, pay);
      pay    = rand_pay();
      pay[0] = BIND_MARKER;
      send_good_packet(100, pay);
   endtask

   // Tick timing around period multiples and the divide-down past 16 hops
   task automatic test_hop_timing();
      logic [31:0] base;
      send_good_packet(50, rand_pay());
      base = evt_time;
      send_item(REQ_TICK, base + HOP_PERIOD_U - 1, rand_pay());
      send_item(REQ_TICK, base + HOP_PERIOD_U, rand_pay());
      send_item(REQ_TICK, base + 16 * HOP_PERIOD_U, rand_pay());
      send_item(REQ_TICK, base + 17 * HOP_PERIOD_U, rand_pay());
      send_item(REQ_TICK, base + 32'hFFFF_FFFF, rand_pay());
      evt_time = base + 17 * HOP_PERIOD_U + 10;
      send_good_packet(0, rand_pay());
   endtask

   // Failsafe exactly at and just past the limit
   task automatic test_failsafe_limit();
      write_csr(CSR_FAILSAFE_LIMIT, 24'd0);
      send_good_packet(10, rand_pay());
      send_after(REQ_TICK, 0, rand_pay());
      send_after(REQ_TICK, 1, rand_pay());
      write_csr(CSR_FAILSAFE_LIMIT, 24'd1000);
      send_good_packet(5, rand_pay());
      send_after(REQ_TICK, 1000, rand_pay());
      send_after(REQ_TICK, 1, rand_pay());
   endtask

   // Hold the output for a long stretch while items keep coming
   task automatic test_backpressure();
      write_csr(CSR_FAILSAFE_LIMIT, 24'd50000);
      req_gap_max     = 0;
      rsp_hold_cycles = 120;
      repeat (40) send_random_item();
      req_gap_max     = 16;
   endtask

   // Long random runs under several limits and idling styles
   task automatic test_random_traffic();
      logic [23:0] limits[6];
      limits = '{24'd20000, 24'd0, 24'hFF_FFFF, 24'd1000000, 24'd3000, 24'd0};
      limits[5] = 24'($urandom);
      foreach (limits[p]) begin
         write_csr(CSR_BIND_CHANNEL, 24'($urandom_range(0, 127)));
         write_csr(CSR_FAILSAFE_LIMIT, limits[p]);
         repeat (6) begin
            req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            repeat (30) send_random_item();
         end
      end
      rsp_gap_max = 16;
   endtask

   // Result side: random stalls, compare each item with the oldest expectation
   initial begin : rsp_side
      int           stall;
      rsp_word_type act;
      rsp_word_type exp_res;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0)
            stall = rsp_hold_cycles;
         else
            stall = $urandom_range(0, rsp_gap_max);
         rsp_hold_cycles = 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         act = rsp_word_type'(rsp_tdata);
         if (link_result_q.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual %0h",
                     $time, rsp_tdata);
            num_errors++;
         end else begin
            exp_res = link_result_q.pop_front();
            num_checked++;
            check_field("rf_channel", 16'(exp_res.rf_channel), 16'(act.rf_channel));
            check_field("bound", 16'(exp_res.info.bound), 16'(act.info.bound));
            check_field("packet_accepted", 16'(exp_res.info.packet_accepted),
                        16'(act.info.packet_accepted));
            check_field("failsafe_active", 16'(exp_res.info.failsafe_active),
                        16'(act.info.failsafe_active));
            check_field("throttle_value", 16'(exp_res.info.throttle_value),
                        16'(act.info.throttle_value));
            check_field("roll_value", 16'(exp_res.info.roll_value),
                        16'(act.info.roll_value));
            check_field("pitch_value", 16'(exp_res.info.pitch_value),
                        16'(act.info.pitch_value));
            check_field("yaw_value", 16'(exp_res.info.yaw_value),
                        16'(act.info.yaw_value));
            check_field("flip_flag", 16'(exp_res.info.flip_flag),
                        16'(act.info.flip_flag));
            check_field("video_flag", 16'(exp_res.info.video_flag),
                        16'(act.info.video_flag));
            check_field("fs_switch_flag", 16'(exp_res.info.fs_switch_flag),
                        16'(act.info.fs_switch_flag));
            check_field("link_address", exp_res.info.link_address,
                        act.info.link_address);
            check_field("zero fill", 16'(exp_res.pad), 16'(act.pad));
         end
         @(negedge clock);
      end
   end

   // Run watchdog
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = REQ_PACKET;
      csr_valid       = 1'b0;
      csr_index       = CSR_FAILSAFE_LIMIT;
      csr_data        = '0;
      req_gap_max     = 16;
      rsp_gap_max     = 16;
      rsp_hold_cycles = 0;
      num_errors      = 0;
      num_checked     = 0;
      num_items       = 0;
      num_ticks       = 0;
      num_good        = 0;
      num_fs          = 0;
      num_csr_writes  = 0;
      evt_time        = '0;
      reset_link_state();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_bind_mode();
      test_stick_extremes();
      test_hop_timing();
      test_failsafe_limit();
      test_backpressure();
      test_random_traffic();
      drain_results();

      $display("Covered %0d items (%0d hop ticks), %0d accepted packets, %0d in failsafe",
               num_items, num_ticks, num_good, num_fs);
      $display("Checked %0d results across %0d register writes, %0d mismatches",
               num_checked, num_csr_writes, num_errors);
      if (num_errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
